@@ rtl/mahd_pkg.sv @@
// Package: shared types, codes and lookup tables of the MPEG audio header decoder.
package mahd_pkg;

	// Header field codes
	localparam logic [7:0] SyncByte     = 8'hFF;
	localparam logic [2:0] SyncTopBits  = 3'b111;
	localparam logic [1:0] VerMpeg1     = 2'd3;
	localparam logic [1:0] VerMpeg2     = 2'd2;
	localparam logic [1:0] VerReserved  = 2'd1;
	localparam logic [1:0] LayerIII     = 2'd1;
	localparam logic [1:0] ModeMono     = 2'd3;
	localparam logic [1:0] SriReserved  = 2'd3;
	localparam logic [3:0] BriFree      = 4'd0;
	localparam logic [3:0] BriBad       = 4'd15;
	localparam logic [1:0] ChansMono    = 2'd1;
	localparam logic [1:0] ChansStereo  = 2'd2;

	// Arithmetic widths
	localparam int KbpsW     = 9;
	localparam int FactorW   = 18;
	localparam int NumW      = KbpsW + FactorW;
	localparam int RateW     = 16;
	localparam int QuotW     = 12;
	localparam int LenW      = 11;
	localparam int DivSteps  = 3;
	localparam int DivStages = QuotW / DivSteps;

	// 144 or 72 bytes per frame slot, times 1000 bits per kilobit
	localparam logic [FactorW-1:0] Mpeg1Factor = 18'd144000;
	localparam logic [FactorW-1:0] Mpeg2Factor = 18'd72000;

	// Decoded header fields that ride along the whole pipeline
	typedef struct packed {
		logic             sync;
		logic [1:0]       layer;
		logic [RateW-1:0] rate;
		logic [1:0]       chans;
		logic             len_ok;
		logic             pad;
	} hdr_info_t;

	// First stage: decoded fields plus multiplier operands
	typedef struct packed {
		hdr_info_t        info;
		logic [KbpsW-1:0] kbps;
		logic             mpeg1;
	} dec_t;

	// Divider stages: partial remainder and dividend/quotient shift word
	typedef struct packed {
		hdr_info_t        info;
		logic [RateW-1:0] rem;
		logic [QuotW-1:0] work;
	} div_t;

	// Bitrate in kbit/s for Layer III
	function automatic logic [KbpsW-1:0] kbps_lookup(input logic mpeg1, input logic [3:0] bri);
		logic [KbpsW-1:0] k;
		k = '0;
		if (mpeg1) begin
			case (bri)
				4'd1:    k = 9'd32;
				4'd2:    k = 9'd40;
				4'd3:    k = 9'd48;
				4'd4:    k = 9'd56;
				4'd5:    k = 9'd64;
				4'd6:    k = 9'd80;
				4'd7:    k = 9'd96;
				4'd8:    k = 9'd112;
				4'd9:    k = 9'd128;
				4'd10:   k = 9'd160;
				4'd11:   k = 9'd192;
				4'd12:   k = 9'd224;
				4'd13:   k = 9'd256;
				4'd14:   k = 9'd320;
				default: k = '0;
			endcase
		end else begin
			case (bri)
				4'd1:    k = 9'd8;
				4'd2:    k = 9'd16;
				4'd3:    k = 9'd24;
				4'd4:    k = 9'd32;
				4'd5:    k = 9'd40;
				4'd6:    k = 9'd48;
				4'd7:    k = 9'd56;
				4'd8:    k = 9'd64;
				4'd9:    k = 9'd80;
				4'd10:   k = 9'd96;
				4'd11:   k = 9'd112;
				4'd12:   k = 9'd128;
				4'd13:   k = 9'd144;
				4'd14:   k = 9'd160;
				default: k = '0;
			endcase
		end
		return k;
	endfunction

	// Sample rate in Hz; reserved version uses the MPEG2.5 rates
	function automatic logic [RateW-1:0] rate_lookup(input logic [1:0] ver, input logic [1:0] sri);
		logic [RateW-1:0] r;
		r = '0;
		case (ver)
			VerMpeg1: begin
				case (sri)
					2'd0:    r = 16'd44100;
					2'd1:    r = 16'd48000;
					2'd2:    r = 16'd32000;
					default: r = '0;
				endcase
			end
			VerMpeg2: begin
				case (sri)
					2'd0:    r = 16'd22050;
					2'd1:    r = 16'd24000;
					2'd2:    r = 16'd16000;
					default: r = '0;
				endcase
			end
			default: begin
				case (sri)
					2'd0:    r = 16'd11025;
					2'd1:    r = 16'd12000;
					2'd2:    r = 16'd8000;
					default: r = '0;
				endcase
			end
		endcase
		return r;
	endfunction

endpackage

@@ rtl/mahd_if.sv @@
// Interfaces: header input channel and decoded result channel.
interface mahd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] header_byte0;
	logic [7:0] header_byte1;
	logic [7:0] header_byte2;
	logic [7:0] header_byte3;

	modport source (output valid, header_byte0, header_byte1, header_byte2, header_byte3,
		input ready);
	modport sink (input valid, header_byte0, header_byte1, header_byte2, header_byte3,
		output ready);
endinterface

interface mahd_out_if;
	logic        valid;
	logic        ready;
	logic        sync_found;
	logic [1:0]  layer_code;
	logic [15:0] sample_rate_hz;
	logic [1:0]  channel_count;
	logic        length_valid;
	logic [10:0] frame_length;

	modport source (output valid, sync_found, layer_code, sample_rate_hz, channel_count,
		length_valid, frame_length, input ready);
	modport sink (input valid, sync_found, layer_code, sample_rate_hz, channel_count,
		length_valid, frame_length, output ready);
endinterface

@@ rtl/mahd_decode.sv @@
// Header field decode, table lookup and dividend multiply (pipeline stages 1 and 2).
module mahd_decode (
	input  logic           clk,
	input  logic           arst_n,
	mahd_in_if.sink        header,
	output mahd_pkg::div_t out_data,
	output logic           out_valid,
	input  logic           out_ready
);
	import mahd_pkg::*;

	logic [1:0]             ver;
	logic [1:0]             layer;
	logic [3:0]             bri;
	logic [1:0]             sri;
	logic [1:0]             mode;
	logic                   sync;
	dec_t                   dec;
	dec_t                   dec_s1;
	logic                   v_s1;
	logic                   rdy_s1;
	logic [FactorW-1:0]     factor;
	logic [NumW-1:0]        num;
	div_t                   div_s2;
	logic                   v_s2;
	logic                   rdy_s2;

	// Split the header into fields
	assign sync  = (header.header_byte0 == SyncByte) && (header.header_byte1[7:5] == SyncTopBits);
	assign ver   = header.header_byte1[4:3];
	assign layer = header.header_byte1[2:1];
	assign bri   = header.header_byte2[7:4];
	assign sri   = header.header_byte2[3:2];
	assign mode  = header.header_byte3[7:6];

	// Decode fields; zero everything without sync
	always_comb begin
		dec = '0;
		if (sync) begin
			dec.info.sync   = 1'b1;
			dec.info.layer  = layer;
			dec.info.rate   = (sri == SriReserved) ? '0 : rate_lookup(ver, sri);
			dec.info.chans  = (mode == ModeMono) ? ChansMono : ChansStereo;
			dec.info.len_ok = (ver != VerReserved) && (layer == LayerIII) &&
				(bri != BriFree) && (bri != BriBad) && (sri != SriReserved);
			dec.info.pad    = header.header_byte2[1];
			dec.mpeg1       = (ver == VerMpeg1);
			dec.kbps        = dec.info.len_ok ? kbps_lookup(dec.mpeg1, bri) : '0;
		end
	end

	// Handshake: a stage loads when empty or when its item moves on
	assign rdy_s2       = !v_s2 || out_ready;
	assign rdy_s1       = !v_s1 || rdy_s2;
	assign header.ready = rdy_s1;

	// Stage 1 register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (rdy_s1) begin
			v_s1 <= header.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s1 && header.valid) begin
			dec_s1 <= dec;
		end
	end

	// Dividend: bitrate times slot factor
	assign factor = dec_s1.mpeg1 ? Mpeg1Factor : Mpeg2Factor;
	assign num    = NumW'(dec_s1.kbps) * NumW'(factor);

	// Stage 2 register; upper dividend bits seed the remainder
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (rdy_s2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (rdy_s2 && v_s1) begin
			div_s2.info <= dec_s1.info;
			div_s2.rem  <= RateW'(num[NumW-1:QuotW]);
			div_s2.work <= num[QuotW-1:0];
		end
	end

	assign out_data  = div_s2;
	assign out_valid = v_s2;

endmodule

@@ rtl/mahd_div_stage.sv @@
// One stage of the restoring divider: three quotient bits per stage.
module mahd_div_stage (
	input  logic           clk,
	input  logic           arst_n,
	input  mahd_pkg::div_t in_data,
	input  logic           in_valid,
	output logic           in_ready,
	output mahd_pkg::div_t out_data,
	output logic           out_valid,
	input  logic           out_ready
);
	import mahd_pkg::*;

	div_t           nxt;
	logic [RateW:0] trial;
	div_t           div_s;
	logic           v_s;

	// Shift one dividend bit into the remainder per step, subtract when it fits
	always_comb begin
		nxt   = in_data;
		trial = '0;
		for (int i = 0; i < DivSteps; i++) begin
			trial    = {nxt.rem, nxt.work[QuotW-1]};
			nxt.work = {nxt.work[QuotW-2:0], 1'b0};
			if (trial >= {1'b0, nxt.info.rate}) begin
				trial       = trial - {1'b0, nxt.info.rate};
				nxt.work[0] = 1'b1;
			end
			nxt.rem = trial[RateW-1:0];
		end
	end

	// Load when empty or when the held item moves on
	assign in_ready = !v_s || out_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s <= 1'b0;
		end else if (in_ready) begin
			v_s <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			div_s <= nxt;
		end
	end

	assign out_data  = div_s;
	assign out_valid = v_s;

endmodule

@@ rtl/mpeg_audio_header_decoder_unit.sv @@
// Top level: MPEG audio frame header decoder with pipelined frame length divider.
// Takes one four-byte candidate header per cycle while the output side is ready, and
// returns one result per header, in order. Stage 1 decodes the fields and looks up
// sample rate and bitrate, stage 2 multiplies the bitrate by the slot factor, and four
// divider stages each resolve three quotient bits of that product over sample rate;
// the last divider stage is the output register. Sustained rate is one item per cycle;
// a stall on the result side backs up the pipeline without losing items, and empty
// stages keep accepting while a result waits. Fields are zero without sync, and the
// frame length is zero unless length_valid is set.
module mpeg_audio_header_decoder_unit (
	input  logic     clk,
	input  logic     arst_n,
	mahd_in_if.sink  header,
	mahd_out_if.source result
);
	import mahd_pkg::*;

	div_t div_d   [DivStages+1];
	logic div_v   [DivStages+1];
	logic div_rdy [DivStages+1];
	div_t fin;

	mahd_decode u_decode (
		.clk       (clk),
		.arst_n    (arst_n),
		.header    (header),
		.out_data  (div_d[0]),
		.out_valid (div_v[0]),
		.out_ready (div_rdy[0])
	);

	// Divider chain
	for (genvar g = 0; g < DivStages; g++) begin : g_div
		mahd_div_stage u_div (
			.clk       (clk),
			.arst_n    (arst_n),
			.in_data   (div_d[g]),
			.in_valid  (div_v[g]),
			.in_ready  (div_rdy[g]),
			.out_data  (div_d[g+1]),
			.out_valid (div_v[g+1]),
			.out_ready (div_rdy[g+1])
		);
	end

	assign div_rdy[DivStages] = result.ready;
	assign fin                = div_d[DivStages];

	// Format the result item
	assign result.valid          = div_v[DivStages];
	assign result.sync_found     = fin.info.sync;
	assign result.layer_code     = fin.info.layer;
	assign result.sample_rate_hz = fin.info.rate;
	assign result.channel_count  = fin.info.chans;
	assign result.length_valid   = fin.info.len_ok;
	assign result.frame_length   = fin.info.len_ok ?
		(fin.work[LenW-1:0] + LenW'(fin.info.pad)) : '0;

endmodule
